// File: sv/dhcp_request_classifier_assert.svh
// Assertion macros for the DHCP request classifier.
// Expects clk and rst_n in the scope of each use.
`ifndef DHCP_REQUEST_CLASSIFIER_ASSERT_SVH
`define DHCP_REQUEST_CLASSIFIER_ASSERT_SVH

// same-cycle implication, off during reset
`define DRC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define DRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/dhcprc_pkg.sv
// Shared types and constants for the DHCP request classifier.
// No dependencies.
package dhcprc_pkg;

    localparam int OPTIONS_START = 240;
    localparam int TYPE_OFFSET   = 2;

    localparam logic [7:0] OPT_SERVER_ID = 8'd54;
    localparam logic [7:0] OPT_REQ_ADDR  = 8'd50;
    localparam logic [7:0] OPT_END       = 8'hff;

    localparam logic [7:0] MSG_DISCOVER = 8'd1;
    localparam logic [7:0] MSG_REQUEST  = 8'd3;

    localparam logic [15:0] POOL_START     = 16'h0164;
    localparam logic [15:0] POOL_SKIP_LOW  = 16'd101;
    localparam logic [15:0] POOL_SKIP_HIGH = 16'h0200;

    localparam logic [31:0] SERVER_ADDR_RESET = 32'd3232236040;
    localparam logic [15:0] POOL_PREFIX_RESET = 16'd49320;

    // register index, taken from paddr[2]
    localparam logic REG_SERVER_ADDR = 1'b0;
    localparam logic REG_POOL_PREFIX = 1'b1;

    typedef enum logic [1:0] {
        REPLY_NONE  = 2'd0,
        REPLY_OFFER = 2'd1,
        REPLY_ACK   = 2'd2,
        REPLY_NAK   = 2'd3
    } reply_kind_t;

endpackage

// File: sv/dhcp_request_classifier.sv
// DHCP request classifier: option walk, server-id / requested-address capture, reply decision.
// Depends on dhcprc_pkg and dhcp_request_classifier_assert.svh.
//
// Packet bytes enter on the s_ stream, one request per byte, with s_tlast on the final byte;
// the block takes one byte every cycle unless a waiting decision holds it. Each byte is held in
// an input register, then a single pass of compare and counter logic updates the option walk
// and, on the final byte, writes one decision into the result register, which drives the
// m_ stream. Every packet gives exactly one decision request, also when the kind is no
// reply. A decision not yet taken stalls the byte stream after the input register fills.
// Bytes beyond MAX_PKT_BYTES only count for their tlast mark.
module dhcp_request_classifier #(
    parameter int MAX_PKT_BYTES = 515
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // packet bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pkt_byte
    input  logic        s_tlast,   // pkt_last
    // decisions
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [1:0] reply_kind, [33:2] your_addr, [39:34] zero
);

    localparam int BW = $clog2(MAX_PKT_BYTES + 1);
    localparam int AW = BW + 1;
    localparam logic [BW-1:0] POS_SAT   = {BW{1'b1}};
    localparam logic [BW-1:0] MAX_POS   = BW'(MAX_PKT_BYTES);
    localparam logic [BW-1:0] TYPE_POS  =
        BW'(dhcprc_pkg::OPTIONS_START + dhcprc_pkg::TYPE_OFFSET);
    localparam logic [BW-1:0] START_POS = BW'(dhcprc_pkg::OPTIONS_START);

    // configuration
    logic [31:0] server_addr_reg;
    logic [15:0] pool_prefix_reg;

    // input stage
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // packet state
    logic [BW-1:0] byte_pos_reg, byte_pos_next;
    logic [7:0]    msg_type_reg, msg_type_next;
    logic [BW-1:0] next_opt_pos_reg, next_opt_pos_next;
    logic          walk_done_reg, walk_done_next;
    logic          len_next_reg, len_next_next;
    logic          srv_found_reg, srv_found_next;
    logic [AW-1:0] srv_at_reg, srv_at_next;
    logic [31:0]   srv_value_reg, srv_value_next;
    logic          req_found_reg, req_found_next;
    logic [AW-1:0] req_at_reg, req_at_next;
    logic [31:0]   req_value_reg, req_value_next;
    logic [15:0]   pool_next_reg, pool_next_next;

    // result stage
    logic                    out_valid_reg, out_valid_next;
    dhcprc_pkg::reply_kind_t out_kind_reg, out_kind_next;
    logic [31:0]             out_addr_reg, out_addr_next;

    logic          advance;
    logic          step;
    logic          cfg_write;
    logic [AW-1:0] p_ext;
    logic [AW-1:0] opt_end_pos;
    logic          srv_ok;
    logic          req_ok;
    logic [31:0]   offer;
    logic [15:0]   pool_inc;
    logic [15:0]   pool_skip1;
    logic [15:0]   pool_skip2;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        case (paddr[2])
            dhcprc_pkg::REG_SERVER_ADDR: prdata = server_addr_reg;
            dhcprc_pkg::REG_POOL_PREFIX: prdata = {16'd0, pool_prefix_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_addr_reg <= dhcprc_pkg::SERVER_ADDR_RESET;
            pool_prefix_reg <= dhcprc_pkg::POOL_PREFIX_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == dhcprc_pkg::REG_SERVER_ADDR)
                server_addr_reg <= pwdata;
            else
                pool_prefix_reg <= pwdata[15:0];
        end
    end

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // pool advance with skips over hosts .255 to .99 and over 255.x and 0.x subnets
    assign pool_inc   = pool_next_reg + 16'd1;
    assign pool_skip1 = (pool_inc[7:0] == 8'hff) ? pool_inc + dhcprc_pkg::POOL_SKIP_LOW
                                                 : pool_inc;
    assign pool_skip2 = (pool_skip1[15:8] == 8'hff) ? pool_skip1 + dhcprc_pkg::POOL_SKIP_HIGH
                                                    : pool_skip1;

    assign p_ext       = {1'b0, byte_pos_reg};
    assign opt_end_pos = p_ext + AW'(1) + AW'(in_byte_reg);
    assign offer       = {pool_prefix_reg, pool_next_reg};

    always_comb
    begin
        byte_pos_next     = byte_pos_reg;
        msg_type_next     = msg_type_reg;
        next_opt_pos_next = next_opt_pos_reg;
        walk_done_next    = walk_done_reg;
        len_next_next     = len_next_reg;
        srv_found_next    = srv_found_reg;
        srv_at_next       = srv_at_reg;
        srv_value_next    = srv_value_reg;
        req_found_next    = req_found_reg;
        req_at_next       = req_at_reg;
        req_value_next    = req_value_reg;
        pool_next_next    = pool_next_reg;
        out_kind_next     = out_kind_reg;
        out_addr_next     = out_addr_reg;
        out_valid_next    = m_tready ? 1'b0 : out_valid_reg;
        srv_ok            = 1'b0;
        req_ok            = 1'b0;

        if (step)
        begin
            if (byte_pos_reg < MAX_POS)
            begin
                if (byte_pos_reg == TYPE_POS)
                    msg_type_next = in_byte_reg;

                if (srv_found_reg && p_ext >= srv_at_reg && p_ext < srv_at_reg + AW'(4))
                    srv_value_next = {srv_value_reg[23:0], in_byte_reg};
                if (req_found_reg && p_ext >= req_at_reg && p_ext < req_at_reg + AW'(4))
                    req_value_next = {req_value_reg[23:0], in_byte_reg};

                if (!walk_done_reg)
                begin
                    if (len_next_reg)
                    begin
                        next_opt_pos_next = (opt_end_pos > {1'b0, POS_SAT}) ? POS_SAT
                                                                           : opt_end_pos[BW-1:0];
                        len_next_next = 1'b0;
                    end
                    else if (byte_pos_reg == next_opt_pos_reg)
                    begin
                        if (in_byte_reg == dhcprc_pkg::OPT_END)
                            walk_done_next = 1'b1;
                        else
                        begin
                            if (in_byte_reg == dhcprc_pkg::OPT_SERVER_ID && !srv_found_reg)
                            begin
                                srv_found_next = 1'b1;
                                srv_at_next    = p_ext + AW'(2);
                            end
                            if (in_byte_reg == dhcprc_pkg::OPT_REQ_ADDR && !req_found_reg)
                            begin
                                req_found_next = 1'b1;
                                req_at_next    = p_ext + AW'(2);
                            end
                            len_next_next = 1'b1;
                        end
                    end
                end
                byte_pos_next = byte_pos_reg + BW'(1);
            end

            if (in_last_reg)
            begin
                // an option counts only once all four value bytes arrived
                srv_ok = srv_found_next && ({1'b0, byte_pos_next} >= srv_at_next + AW'(4));
                req_ok = req_found_next && ({1'b0, byte_pos_next} >= req_at_next + AW'(4));

                out_valid_next = 1'b1;
                out_kind_next  = dhcprc_pkg::REPLY_NONE;
                out_addr_next  = 32'd0;
                if (msg_type_next == dhcprc_pkg::MSG_DISCOVER)
                begin
                    out_kind_next = dhcprc_pkg::REPLY_OFFER;
                    out_addr_next = offer;
                end
                else if (msg_type_next == dhcprc_pkg::MSG_REQUEST)
                begin
                    if (srv_ok && srv_value_next != server_addr_reg)
                        out_kind_next = dhcprc_pkg::REPLY_NONE;
                    else if (req_ok && req_value_next == offer)
                    begin
                        out_kind_next  = dhcprc_pkg::REPLY_ACK;
                        out_addr_next  = offer;
                        pool_next_next = pool_skip2;
                    end
                    else
                        out_kind_next = dhcprc_pkg::REPLY_NAK;
                end

                byte_pos_next     = '0;
                msg_type_next     = 8'd0;
                next_opt_pos_next = START_POS;
                walk_done_next    = 1'b0;
                len_next_next     = 1'b0;
                srv_found_next    = 1'b0;
                srv_at_next       = '0;
                srv_value_next    = 32'd0;
                req_found_next    = 1'b0;
                req_at_next       = '0;
                req_value_next    = 32'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg     <= '0;
            msg_type_reg     <= 8'd0;
            next_opt_pos_reg <= START_POS;
            walk_done_reg    <= 1'b0;
            len_next_reg     <= 1'b0;
            srv_found_reg    <= 1'b0;
            srv_at_reg       <= '0;
            srv_value_reg    <= 32'd0;
            req_found_reg    <= 1'b0;
            req_at_reg       <= '0;
            req_value_reg    <= 32'd0;
            pool_next_reg    <= dhcprc_pkg::POOL_START;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            byte_pos_reg     <= byte_pos_next;
            msg_type_reg     <= msg_type_next;
            next_opt_pos_reg <= next_opt_pos_next;
            walk_done_reg    <= walk_done_next;
            len_next_reg     <= len_next_next;
            srv_found_reg    <= srv_found_next;
            srv_at_reg       <= srv_at_next;
            srv_value_reg    <= srv_value_next;
            req_found_reg    <= req_found_next;
            req_at_reg       <= req_at_next;
            req_value_reg    <= req_value_next;
            pool_next_reg    <= pool_next_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_addr_reg <= out_addr_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_addr_reg, out_kind_reg};

`include "dhcp_request_classifier_assert.svh"

    `DRC_ASSERT_NEXT(a_ack_moves_pool, step && in_last_reg && out_kind_next == dhcprc_pkg::REPLY_ACK, pool_next_reg != $past(pool_next_reg), "ack did not advance pool")
    `DRC_ASSERT_NEXT(a_last_clears, step && in_last_reg, byte_pos_reg == '0 && !srv_found_reg && !req_found_reg && !walk_done_reg, "packet state not cleared after last byte")
    `DRC_ASSERT_IMPL(a_no_addr, m_tvalid && (out_kind_reg == dhcprc_pkg::REPLY_NONE || out_kind_reg == dhcprc_pkg::REPLY_NAK), out_addr_reg == 32'd0, "address set on nak or no reply")
    `DRC_ASSERT_IMPL(a_pos_bound, 1'b1, byte_pos_reg <= MAX_POS, "byte position beyond packet limit")

endmodule
